/* src/hed_pkg.sv */
// Shared constants and types of the HTML entity decoder.
package hed_pkg;

	localparam int MAX_ENTITY_LEN = 20;
	localparam int LEN_W          = 5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [15:0] CH_AMP  = 16'h0026;
	localparam logic [15:0] CH_HASH = 16'h0023;
	localparam logic [15:0] CH_SEMI = 16'h003B;
	localparam logic [15:0] CH_X    = 16'h0078;

	localparam logic [20:0] CP_MAX = 21'h10FFFF;

	// One queued job for the back end: a decoded code point and/or a plain unit, or neither, plus a string-end flag.
	typedef struct packed {
		logic        code_en;
		logic [20:0] code;
		logic        unit_en;
		logic [15:0] unit;
		logic        str_end;
	} hed_rec_t;

	typedef struct packed {
		logic empty;
		logic full;
	} hed_qstat_t;

endpackage

/* src/html_entity_decoder.sv */
// Top level of the HTML entity decoder.
//
// Input channel text_valid/text_stall moves one word per cycle: kind 0 with
// a UTF-16 code unit, or kind 1 to close the string. Output channel
// dec_valid/dec_stall returns decoded words with unit_valid, string_end and
// last_of_run flags. Both sides use valid with stall; a word moves at an
// edge where valid is high and stall is low.
// The front end takes one input word every cycle and never waits on the
// output directly; it stalls only when its four-entry job queue is full.
// The back end sends one output word per cycle while dec_stall is low, so
// an input word that yields up to three results holds the back end for one
// output word per result; words that yield nothing (inside an entity) take
// no back-end time. Results pass through a queue entry and then the output
// register.
// When the receiver stalls, the output register holds its word and the
// queue absorbs up to four jobs before the input side is stalled.
// Reset clears the parser to plain text and empties the queue.
module html_entity_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic        kind,
	input  logic [15:0] code_unit,
	output logic        dec_valid,
	input  logic        dec_stall,
	output logic [15:0] out_unit,
	output logic        unit_valid,
	output logic        string_end,
	output logic        last_of_run
);
	import hed_pkg::*;

	hed_rec_t   wr_rec, head;
	hed_qstat_t qstat;
	logic       push, pop;

	hed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.kind       (kind),
		.code_unit  (code_unit),
		.qstat      (qstat),
		.push       (push),
		.rec        (wr_rec)
	);

	hed_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	hed_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.qstat       (qstat),
		.pop         (pop),
		.dec_valid   (dec_valid),
		.dec_stall   (dec_stall),
		.out_unit    (out_unit),
		.unit_valid  (unit_valid),
		.string_end  (string_end),
		.last_of_run (last_of_run)
	);

endmodule

/* src/hed_front.sv */
// Front end: accepts text words, tracks entity parsing and queues emission jobs.
module hed_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              text_valid,
	output logic              text_stall,
	input  logic              kind,
	input  logic [15:0]       code_unit,
	input  hed_pkg::hed_qstat_t qstat,
	output logic              push,
	output hed_pkg::hed_rec_t rec
);
	import hed_pkg::*;

	localparam logic [2:0] MODE_TEXT = 3'd0;
	localparam logic [2:0] MODE_AMP  = 3'd1;
	localparam logic [2:0] MODE_NAME = 3'd2;
	localparam logic [2:0] MODE_NUM  = 3'd3;
	localparam logic [2:0] MODE_DEC  = 3'd4;
	localparam logic [2:0] MODE_HEX  = 3'd5;

	function automatic logic [15:0] ch(input logic [7:0] c);
		return {8'h00, c};
	endfunction

	function automatic logic is_space(input logic [15:0] u);
		return (u >= 16'h0009 && u <= 16'h000D) || u == 16'h0020 ||
			u == 16'h0085 || u == 16'h00A0;
	endfunction

	logic [2:0]       mode_q, mode_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [15:0]      prefix_q [4];
	logic [20:0]      value_q, value_d;
	logic             invalid_q, inv_d;

	logic        accept;
	logic        dig_ok;
	logic [3:0]  dig;
	logic [24:0] scaled, sum;
	logic [20:0] name_c, fin_code;
	logic        code_ok;
	logic        finishing, unit_en, start, do_digit, pf_we;

	assign text_stall = qstat.full;
	assign accept     = text_valid && !text_stall;

	always_comb begin
		dig_ok = 1'b0;
		dig    = 4'd0;
		if (code_unit >= ch("0") && code_unit <= ch("9")) begin
			dig_ok = 1'b1;
			dig    = code_unit[3:0];
		end else if (mode_q == MODE_HEX && ((code_unit >= ch("a") && code_unit <= ch("f")) ||
				(code_unit >= ch("A") && code_unit <= ch("F")))) begin
			dig_ok = 1'b1;
			dig    = code_unit[3:0] + 4'd9;
		end
	end

	assign scaled = (mode_q == MODE_HEX) ? {value_q, 4'b0000} :
		({1'b0, value_q, 3'b000} + {3'b000, value_q, 1'b0});
	assign sum    = scaled + {21'd0, dig};

	always_comb begin
		name_c = 21'd0;
		if (len_q == LEN_W'(4) && prefix_q[0] == ch("q") && prefix_q[1] == ch("u") &&
				prefix_q[2] == ch("o") && prefix_q[3] == ch("t")) begin
			name_c = 21'h22;
		end else if (len_q == LEN_W'(4) && prefix_q[0] == ch("a") && prefix_q[1] == ch("p") &&
				prefix_q[2] == ch("o") && prefix_q[3] == ch("s")) begin
			name_c = 21'h27;
		end else if (len_q == LEN_W'(2) && prefix_q[0] == ch("l") && prefix_q[1] == ch("t")) begin
			name_c = 21'h3C;
		end else if (len_q == LEN_W'(2) && prefix_q[0] == ch("g") && prefix_q[1] == ch("t")) begin
			name_c = 21'h3E;
		end else if (len_q == LEN_W'(3) && prefix_q[0] == ch("a") && prefix_q[1] == ch("m") &&
				prefix_q[2] == ch("p")) begin
			name_c = 21'h26;
		end
	end

	always_comb begin
		case (mode_q)
			MODE_NAME: fin_code = name_c;
			MODE_DEC:  fin_code = invalid_q ? 21'd0 : value_q;
			MODE_HEX:  fin_code = (!invalid_q && len_q > LEN_W'(1)) ? value_q : 21'd0;
			default:   fin_code = 21'd0;
		endcase
	end

	assign code_ok = fin_code != 21'd0 && fin_code <= CP_MAX;

	always_comb begin
		mode_d    = mode_q;
		len_d     = len_q;
		value_d   = value_q;
		inv_d     = invalid_q;
		finishing = 1'b0;
		unit_en   = 1'b0;
		start     = 1'b0;
		do_digit  = 1'b0;
		pf_we     = 1'b0;
		if (kind) begin
			finishing = mode_q != MODE_TEXT;
			mode_d    = MODE_TEXT;
		end else if (mode_q == MODE_TEXT) begin
			if (code_unit == CH_AMP) start = 1'b1;
			else unit_en = 1'b1;
		end else if (mode_q == MODE_AMP && code_unit == CH_HASH) begin
			mode_d = MODE_NUM;
		end else if (code_unit == CH_SEMI || is_space(code_unit) ||
				len_q >= LEN_W'(MAX_ENTITY_LEN)) begin
			finishing = 1'b1;
			mode_d    = MODE_TEXT;
			if (code_unit != CH_SEMI) begin
				if (code_unit == CH_AMP) start = 1'b1;
				else unit_en = 1'b1;
			end
		end else begin
			len_d = len_q + LEN_W'(1);
			case (mode_q)
				MODE_AMP, MODE_NAME: begin
					mode_d = MODE_NAME;
					pf_we  = len_q < LEN_W'(4);
				end
				MODE_NUM: begin
					if (code_unit == CH_X) begin
						mode_d = MODE_HEX;
					end else begin
						mode_d   = MODE_DEC;
						do_digit = 1'b1;
					end
				end
				MODE_DEC, MODE_HEX: do_digit = 1'b1;
				default: ;
			endcase
		end
		if (start) begin
			mode_d  = MODE_AMP;
			len_d   = '0;
			value_d = 21'd0;
			inv_d   = 1'b0;
		end
		// Once a number is invalid its value is never used again.
		if (do_digit) begin
			if (!dig_ok) begin
				inv_d = 1'b1;
			end else if (!invalid_q) begin
				value_d = sum[20:0];
				inv_d   = sum > {4'd0, CP_MAX};
			end
		end
	end

	assign rec.code_en = finishing && code_ok;
	assign rec.code    = fin_code;
	assign rec.unit_en = unit_en;
	assign rec.unit    = code_unit;
	assign rec.str_end = kind;
	assign push        = accept && (rec.code_en || unit_en || kind);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TEXT;
			len_q     <= '0;
			value_q   <= 21'd0;
			invalid_q <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_d;
			len_q     <= len_d;
			value_q   <= value_d;
			invalid_q <= inv_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pf_we) begin
			prefix_q[len_q[1:0]] <= code_unit;
		end
	end

endmodule

/* src/hed_queue.sv */
// Short job queue between the front and back ends.
module hed_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hed_pkg::hed_rec_t   wr_rec,
	input  logic                pop,
	output hed_pkg::hed_rec_t   head,
	output hed_pkg::hed_qstat_t qstat
);
	import hed_pkg::*;

	hed_rec_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign qstat.empty = cnt_q == '0;
	assign qstat.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

endmodule

/* src/hed_back.sv */
// Back end: expands queued jobs into output words through an output register.
module hed_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hed_pkg::hed_rec_t   head,
	input  hed_pkg::hed_qstat_t qstat,
	output logic                pop,
	output logic                dec_valid,
	input  logic                dec_stall,
	output logic [15:0]         out_unit,
	output logic                unit_valid,
	output logic                string_end,
	output logic                last_of_run
);
	import hed_pkg::*;

	localparam logic [1:0] PH_CODE = 2'd0;
	localparam logic [1:0] PH_LOW  = 2'd1;
	localparam logic [1:0] PH_UNIT = 2'd2;
	localparam logic [1:0] PH_BARE = 2'd3;

	logic [1:0]  phase_q, start_ph, cur_ph, next_ph;
	logic        first_q;
	logic        big, last, load;
	logic [20:0] off;
	logic [15:0] word;
	logic        word_ok;

	logic        out_valid_q;
	logic [15:0] out_unit_q;
	logic        unit_valid_q, string_end_q, last_q;

	assign big = |head.code[20:16];
	assign off = head.code - 21'h10000;

	always_comb begin
		if (head.code_en) start_ph = PH_CODE;
		else if (head.unit_en) start_ph = PH_UNIT;
		else start_ph = PH_BARE;
	end

	assign cur_ph = first_q ? start_ph : phase_q;

	always_comb begin
		next_ph = PH_BARE;
		last    = 1'b1;
		word    = 16'd0;
		word_ok = 1'b1;
		case (cur_ph)
			PH_CODE: begin
				if (big) begin
					word    = 16'hD800 + {6'd0, off[19:10]};
					next_ph = PH_LOW;
					last    = 1'b0;
				end else begin
					word    = head.code[15:0];
					next_ph = PH_UNIT;
					last    = !head.unit_en;
				end
			end
			PH_LOW: begin
				word    = 16'hDC00 + {6'd0, off[9:0]};
				next_ph = PH_UNIT;
				last    = !head.unit_en;
			end
			PH_UNIT: word = head.unit;
			default: word_ok = 1'b0;
		endcase
	end

	assign load = !qstat.empty && (!out_valid_q || !dec_stall);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			first_q     <= 1'b1;
			phase_q     <= PH_CODE;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				first_q     <= last;
				phase_q     <= next_ph;
			end else if (!dec_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_unit_q   <= word;
			unit_valid_q <= word_ok;
			string_end_q <= head.str_end && last;
			last_q       <= last;
		end
	end

	assign dec_valid   = out_valid_q;
	assign out_unit    = out_unit_q;
	assign unit_valid  = unit_valid_q;
	assign string_end  = string_end_q;
	assign last_of_run = last_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && string_end |-> last_of_run)
		else $error("string end on a word that is not the last of its run");
	a_bare_word: assert property (@(posedge clk) disable iff (!arst_n)
		dec_valid && !unit_valid |-> string_end && out_unit == 16'd0)
		else $error("bare word without string end or with nonzero unit");

endmodule
